// ----- sv/klerp_pkg.sv -----
// shared types and constants of the keyframe linear interpolator
`timescale 1ns / 1ps

package klerp_pkg;

   localparam int DEPTH = 64;
   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int DIV_STEPS = 16;
   localparam int DIV_CW = $clog2(DIV_STEPS);

   localparam logic ACTION_APPEND = 1'b0;
   localparam logic ACTION_QUERY = 1'b1;

   localparam logic [1:0] STATUS_OK = 2'd0;
   localparam logic [1:0] STATUS_FULL = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   typedef struct packed {
      logic               action;
      logic [15:0]        key_frame;
      logic signed [15:0] key_value;
   } req_type;

   typedef struct packed {
      logic signed [15:0] out_value;
      logic [1:0]         status;
      logic               past_end;
   } rsp_type;

   typedef struct packed {
      logic [15:0]        frame;
      logic signed [15:0] value;
   } entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LAST,
      ST_SCAN,
      ST_MUL,
      ST_DINIT,
      ST_DIV,
      ST_SUM,
      ST_EMIT
   } state_type;

endpackage

// ----- sv/keyframe_linear_interpolator.sv -----
// keyframe table with linear interpolation between stored keys
//
// requests arrive on req_valid/req_ready with req_data; each request gives
// exactly one response on rsp_valid/rsp_ready with rsp_data.
// an append request writes (key_frame, key_value) at the end of a table of
// DEPTH entries, or reports status full when the table holds DEPTH keys.
// a query request first reads the last key (for past_end), then walks the
// table one entry per cycle from entry 0 until the first segment holding
// the frame; the segment is interpolated with one 16x17 multiply and a
// 16-step restoring divider.
// the time a query takes is set by the table walk through the single read
// port of the key memory and by the serial divider.
// one request is in work at a time; req_ready is high only when idle, and
// a finished response waits in the output register while the next request
// is taken. if the receiver stalls, the next response waits until the
// output register is free.
// reset empties the table at once; the key memory is not cleared.
`timescale 1ns / 1ps

module keyframe_linear_interpolator (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  klerp_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output klerp_pkg::rsp_type rsp_data
);

   klerp_pkg::entry_type mem [klerp_pkg::DEPTH];
   klerp_pkg::entry_type mem_rd_ff;
   logic                 mem_we;
   logic [klerp_pkg::AW-1:0] mem_waddr;
   logic [klerp_pkg::AW-1:0] mem_raddr;
   klerp_pkg::entry_type mem_wdata;

   klerp_pkg::state_type state_ff, state_in;
   logic [klerp_pkg::CW-1:0] count_ff, count_in;
   logic [klerp_pkg::AW-1:0] scan_ff, scan_in;
   logic [15:0]          frame_ff, frame_in;
   logic                 past_ff, past_in;
   klerp_pkg::entry_type prev_ff, prev_in;
   logic [15:0]          d_ff, d_in;
   logic signed [16:0]   dv_ff, dv_in;
   logic [15:0]          den_ff, den_in;
   logic signed [15:0]   base_ff, base_in;
   logic signed [33:0]   prod_ff, prod_in;
   logic                 neg_ff, neg_in;
   logic [15:0]          rem_ff, rem_in;
   logic [15:0]          quo_ff, quo_in;
   logic [klerp_pkg::DIV_CW-1:0] div_cnt_ff, div_cnt_in;
   klerp_pkg::rsp_type   res_ff, res_in;
   klerp_pkg::rsp_type   rsp_ff, rsp_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   logic [klerp_pkg::CW-1:0] cnt_m1;
   logic [klerp_pkg::AW-1:0] last_idx;
   logic                 at_last;
   logic                 hit_first;
   logic                 hit_seg;
   logic [33:0]          mag;
   logic [16:0]          shifted;
   logic                 div_ge;
   logic [16:0]          div_diff;
   logic signed [17:0]   qs;
   logic signed [17:0]   sum;
   logic                 out_free;

   assign cnt_m1 = count_ff - klerp_pkg::CW'(1);
   assign last_idx = cnt_m1[klerp_pkg::AW-1:0];
   assign at_last = (scan_ff == last_idx);
   assign hit_first = (scan_ff == '0) && (frame_ff < mem_rd_ff.frame);
   assign hit_seg = (scan_ff != '0) && (frame_ff >= prev_ff.frame)
                    && (frame_ff < mem_rd_ff.frame);
   assign mag = prod_ff[33] ? 34'(-prod_ff) : 34'(prod_ff);
   assign shifted = {rem_ff, quo_ff[15]};
   assign div_ge = (shifted >= {1'b0, den_ff});
   assign div_diff = shifted - {1'b0, den_ff};
   assign qs = neg_ff ? -$signed({2'b00, quo_ff}) : $signed({2'b00, quo_ff});
   assign sum = 18'(base_ff) + qs;
   assign out_free = !rsp_valid_ff || rsp_ready;

   assign req_ready = (state_ff == klerp_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      mem_rd_ff <= mem[mem_raddr];
   end

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      scan_in = scan_ff;
      frame_in = frame_ff;
      past_in = past_ff;
      prev_in = prev_ff;
      d_in = d_ff;
      dv_in = dv_ff;
      den_in = den_ff;
      base_in = base_ff;
      prod_in = prod_ff;
      neg_in = neg_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      div_cnt_in = div_cnt_ff;
      res_in = res_ff;
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      mem_we = 1'b0;
      mem_waddr = count_ff[klerp_pkg::AW-1:0];
      mem_wdata.frame = req_data.key_frame;
      mem_wdata.value = req_data.key_value;
      mem_raddr = last_idx;

      unique case (state_ff)
         klerp_pkg::ST_IDLE: begin
            if (req_valid) begin
               res_in.out_value = '0;
               res_in.status = klerp_pkg::STATUS_OK;
               res_in.past_end = 1'b0;
               frame_in = req_data.key_frame;
               if (req_data.action == klerp_pkg::ACTION_APPEND) begin
                  if (count_ff == klerp_pkg::CW'(klerp_pkg::DEPTH)) begin
                     res_in.status = klerp_pkg::STATUS_FULL;
                  end else begin
                     mem_we = 1'b1;
                     count_in = count_ff + klerp_pkg::CW'(1);
                  end
                  state_in = klerp_pkg::ST_EMIT;
               end else if (count_ff == '0) begin
                  res_in.status = klerp_pkg::STATUS_EMPTY;
                  res_in.past_end = (req_data.key_frame != '0);
                  state_in = klerp_pkg::ST_EMIT;
               end else begin
                  state_in = klerp_pkg::ST_LAST;
               end
            end
         end
         klerp_pkg::ST_LAST: begin
            past_in = (frame_ff > mem_rd_ff.frame);
            mem_raddr = '0;
            scan_in = '0;
            state_in = klerp_pkg::ST_SCAN;
         end
         klerp_pkg::ST_SCAN: begin
            if (hit_seg) begin
               d_in = frame_ff - prev_ff.frame;
               dv_in = 17'(mem_rd_ff.value) - 17'(prev_ff.value);
               den_in = mem_rd_ff.frame - prev_ff.frame;
               base_in = prev_ff.value;
               state_in = klerp_pkg::ST_MUL;
            end else if (hit_first || at_last) begin
               res_in.out_value = mem_rd_ff.value;
               res_in.past_end = past_ff;
               state_in = klerp_pkg::ST_EMIT;
            end else begin
               prev_in = mem_rd_ff;
               scan_in = scan_ff + klerp_pkg::AW'(1);
               mem_raddr = scan_ff + klerp_pkg::AW'(1);
            end
         end
         klerp_pkg::ST_MUL: begin
            prod_in = $signed({1'b0, d_ff}) * dv_ff;
            state_in = klerp_pkg::ST_DINIT;
         end
         klerp_pkg::ST_DINIT: begin
            neg_in = prod_ff[33];
            rem_in = mag[31:16];
            quo_in = mag[15:0];
            div_cnt_in = '0;
            state_in = klerp_pkg::ST_DIV;
         end
         klerp_pkg::ST_DIV: begin
            rem_in = div_ge ? div_diff[15:0] : shifted[15:0];
            quo_in = {quo_ff[14:0], div_ge};
            div_cnt_in = div_cnt_ff + klerp_pkg::DIV_CW'(1);
            if (div_cnt_ff == klerp_pkg::DIV_CW'(klerp_pkg::DIV_STEPS - 1)) begin
               state_in = klerp_pkg::ST_SUM;
            end
         end
         klerp_pkg::ST_SUM: begin
            res_in.out_value = sum[15:0];
            res_in.past_end = past_ff;
            state_in = klerp_pkg::ST_EMIT;
         end
         klerp_pkg::ST_EMIT: begin
            if (out_free) begin
               rsp_in = res_ff;
               rsp_valid_in = 1'b1;
               state_in = klerp_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = klerp_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= klerp_pkg::ST_IDLE;
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff <= scan_in;
      frame_ff <= frame_in;
      past_ff <= past_in;
      prev_ff <= prev_in;
      d_ff <= d_in;
      dv_ff <= dv_in;
      den_ff <= den_in;
      base_ff <= base_in;
      prod_ff <= prod_in;
      neg_ff <= neg_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_cnt_ff <= div_cnt_in;
      res_ff <= res_in;
      rsp_ff <= rsp_in;
   end

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= klerp_pkg::CW'(klerp_pkg::DEPTH))
      else $error("entry count beyond table depth");

   a_write_on_append: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == klerp_pkg::ST_IDLE) && req_valid
                 && (req_data.action == klerp_pkg::ACTION_APPEND))
      else $error("table write outside an append request");

   a_rem_below_den: assert property (@(posedge clock) disable iff (reset)
      (state_ff == klerp_pkg::ST_DIV) |-> (rem_ff < den_ff))
      else $error("divider remainder not below divisor");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_ff.status == klerp_pkg::STATUS_EMPTY)
      |-> (rsp_ff.out_value == '0))
      else $error("empty table response with nonzero level");

   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == klerp_pkg::ST_EMIT))
      else $error("response raised outside emit state");
`endif

endmodule

// ----- tb/sv/tb_keyframe_linear_interpolator.sv -----
// testbench for the keyframe linear interpolator: directed and random requests
`timescale 1ns / 1ps

module tb_keyframe_linear_interpolator;

   localparam int IDLE_LIMIT = 2000;
   localparam int RANDOM_COUNT = 850;
   localparam int LONG_HOLD = 300;
   localparam int DRAIN_CYCLES = 100;

   class keyframe_table;
      logic [15:0]        frames[klerp_pkg::DEPTH];
      logic signed [15:0] levels[klerp_pkg::DEPTH];
      int unsigned        count;
      klerp_pkg::rsp_type due_responses[$];
      int                 errors;

      function new();
         count = 0;
         errors = 0;
      endfunction

      function int pending();
         return due_responses.size();
      endfunction

      function klerp_pkg::rsp_type predict_response(klerp_pkg::req_type r);
         klerp_pkg::rsp_type p;
         int unsigned last;
         longint f;
         longint f0;
         longint f1;
         longint num;
         longint den;
         bit found;
         p = '0;
         p.status = klerp_pkg::STATUS_OK;
         if (r.action == klerp_pkg::ACTION_APPEND) begin
            if (count >= klerp_pkg::DEPTH) begin
               p.status = klerp_pkg::STATUS_FULL;
            end else begin
               frames[count] = r.key_frame;
               levels[count] = r.key_value;
               count++;
            end
         end else if (count == 0) begin
            p.status = klerp_pkg::STATUS_EMPTY;
            p.past_end = (r.key_frame != 16'd0);
         end else begin
            last = count - 1;
            f = longint'(r.key_frame);
            p.past_end = (f > longint'(frames[last]));
            if (f < longint'(frames[0])) begin
               p.out_value = levels[0];
            end else begin
               p.out_value = levels[last];
               found = 1'b0;
               for (int i = 0; i < int'(last); i++) begin
                  f0 = longint'(frames[i]);
                  f1 = longint'(frames[i + 1]);
                  if (!found && f >= f0 && f < f1) begin
                     num = (f - f0) * (longint'(levels[i + 1]) - longint'(levels[i]));
                     den = f1 - f0;
                     p.out_value = 16'(longint'(levels[i]) + num / den);
                     found = 1'b1;
                  end
               end
            end
         end
         return p;
      endfunction

      function void note_request(klerp_pkg::req_type r);
         due_responses.push_back(predict_response(r));
      endfunction

      function void check_response(klerp_pkg::rsp_type got);
         klerp_pkg::rsp_type want;
         if (due_responses.size() == 0) begin
            $error("response with no request outstanding: out_value %0d status %0d past_end %0d",
                   got.out_value, got.status, got.past_end);
            errors++;
            return;
         end
         want = due_responses.pop_front();
         if (got.out_value !== want.out_value) begin
            $error("out_value expected %0d actual %0d", want.out_value, got.out_value);
            errors++;
         end
         if (got.status !== want.status) begin
            $error("status expected %0d actual %0d", want.status, got.status);
            errors++;
         end
         if (got.past_end !== want.past_end) begin
            $error("past_end expected %0d actual %0d", want.past_end, got.past_end);
            errors++;
         end
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   klerp_pkg::req_type req_data = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   klerp_pkg::rsp_type rsp_data;

   keyframe_table board = new();

   bit          quiet = 1'b0;
   bit          hold_responses = 1'b0;
   int          idle_cycles = 0;
   int          last_frame = 0;
   int unsigned key_frames[$];

   keyframe_linear_interpolator uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            board.note_request(req_data);
         end
         if (rsp_valid && rsp_ready) begin
            board.check_response(rsp_data);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("keyframe_linear_interpolator test failed");
         $finish;
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 60) begin
         return 0;
      end else if (r < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(10, 50);
   endfunction

   function automatic klerp_pkg::req_type make_request(logic action, int frame, int level);
      klerp_pkg::req_type r;
      r.action = action;
      r.key_frame = 16'(frame);
      r.key_value = 16'(level);
      return r;
   endfunction

   function automatic klerp_pkg::req_type random_request();
      klerp_pkg::req_type r;
      int pick;
      int frame;
      pick = $urandom_range(0, 99);
      r.key_value = 16'($urandom);
      if (pick < 12) begin
         r.action = klerp_pkg::ACTION_APPEND;
         if ($urandom_range(0, 9) == 0) begin
            frame = $urandom_range(0, 65535);
         end else begin
            frame = last_frame + $urandom_range(0, 2200);
            if (frame > 65535) begin
               frame = 65535;
            end
            last_frame = frame;
         end
         key_frames.push_back(frame);
      end else begin
         r.action = klerp_pkg::ACTION_QUERY;
         pick = $urandom_range(0, 99);
         if (pick < 40 && key_frames.size() > 0) begin
            frame = int'(key_frames[$urandom_range(0, key_frames.size() - 1)])
                    + $urandom_range(0, 6) - 3;
         end else if (pick < 80) begin
            frame = $urandom_range(0, last_frame + 100);
         end else if (pick < 90) begin
            frame = ($urandom_range(0, 1) == 0) ? 0 : 65535;
         end else begin
            frame = $urandom_range(0, 65535);
         end
         if (frame < 0) begin
            frame = 0;
         end else if (frame > 65535) begin
            frame = 65535;
         end
      end
      r.key_frame = 16'(frame);
      return r;
   endfunction

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic send_request(input klerp_pkg::req_type r);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
      @(negedge clock);
   endtask

   // response side
   initial begin
      int idle_left;
      int r;
      idle_left = 0;
      forever begin
         @(negedge clock);
         if (hold_responses) begin
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD - 1) @(negedge clock);
            hold_responses = 1'b0;
         end else if (idle_left > 0) begin
            rsp_ready <= 1'b0;
            idle_left--;
         end else begin
            rsp_ready <= 1'b1;
            r = $urandom_range(0, 99);
            if (!quiet && r < 15) begin
               idle_left = $urandom_range(1, 3);
            end else if (!quiet && r < 18) begin
               idle_left = $urandom_range(15, 60);
            end
         end
      end
   end

   initial begin
      klerp_pkg::req_type directed[$];
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty table
      directed.push_back(make_request(klerp_pkg::ACTION_QUERY, 0, 0));
      directed.push_back(make_request(klerp_pkg::ACTION_QUERY, 65535, -1));
      // single key: before, at and after it
      directed.push_back(make_request(klerp_pkg::ACTION_APPEND, 100, 256));
      directed.push_back(make_request(klerp_pkg::ACTION_QUERY, 50, 0));
      directed.push_back(make_request(klerp_pkg::ACTION_QUERY, 100, 0));
      directed.push_back(make_request(klerp_pkg::ACTION_QUERY, 200, 0));
      // falling segment, truncation of negative quotients
      directed.push_back(make_request(klerp_pkg::ACTION_APPEND, 1100, -32768));
      directed.push_back(make_request(klerp_pkg::ACTION_QUERY, 101, 0));
      directed.push_back(make_request(klerp_pkg::ACTION_QUERY, 600, 0));
      directed.push_back(make_request(klerp_pkg::ACTION_QUERY, 1099, 0));
      directed.push_back(make_request(klerp_pkg::ACTION_QUERY, 1100, 0));
      // repeated frame, out of order key, top of the frame range
      directed.push_back(make_request(klerp_pkg::ACTION_APPEND, 1100, 32767));
      directed.push_back(make_request(klerp_pkg::ACTION_APPEND, 1000, 0));
      directed.push_back(make_request(klerp_pkg::ACTION_APPEND, 65535, 32767));
      directed.push_back(make_request(klerp_pkg::ACTION_QUERY, 1100, 0));
      directed.push_back(make_request(klerp_pkg::ACTION_QUERY, 1050, 0));
      directed.push_back(make_request(klerp_pkg::ACTION_QUERY, 30000, 0));
      directed.push_back(make_request(klerp_pkg::ACTION_QUERY, 65535, 0));
      directed.push_back(make_request(klerp_pkg::ACTION_APPEND, 0, -32768));
      directed.push_back(make_request(klerp_pkg::ACTION_QUERY, 0, 0));
      directed.push_back(make_request(klerp_pkg::ACTION_QUERY, 65534, 0));
      key_frames = '{100, 1100, 1000, 65535, 0};
      last_frame = 1100;

      foreach (directed[i]) begin
         send_request(directed[i]);
      end

      for (int n = 0; n < RANDOM_COUNT; n++) begin
         if (n == 200) begin
            hold_responses = 1'b1;
         end
         if (n == 400) begin
            req_valid <= 1'b0;
            while (board.pending() != 0) begin
               @(negedge clock);
            end
            @(negedge clock);
         end
         quiet = (n >= 600 && n < 680);
         send_request(random_request());
      end
      req_valid <= 1'b0;

      while (board.pending() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.errors == 0 && board.pending() == 0) begin
         $display("keyframe_linear_interpolator test passed");
      end else begin
         $display("keyframe_linear_interpolator test failed");
      end
      $finish;
   end

endmodule
